[design/srab_pkg.sv]
package srab_pkg;

  localparam int SCREEN_WIDTH  = 1920;
  localparam int SCREEN_HEIGHT = 1080;
  localparam int SOURCE_DEPTH  = 65536;

  localparam int SRC_AW    = (SOURCE_DEPTH > 1) ? $clog2(SOURCE_DEPTH) : 1;
  localparam int DIM_W     = 12;
  localparam int SRC_DIM_W = 9;
  localparam int PROD_W    = DIM_W + SRC_DIM_W;
  localparam int Q_W       = 9;
  localparam int SIDX_W    = 2 * Q_W + 1;
  localparam int FB_W      = 21;
  localparam int CFG_W     = 13;
  localparam int RGB_W     = 24;
  localparam int WORD_W    = 32;

  // pipeline stage numbers
  localparam int ST_DIV_LAST = Q_W;
  localparam int ST_IDX      = ST_DIV_LAST + 1;
  localparam int ST_MEM      = ST_IDX + 1;
  localparam int ST_SUM      = ST_MEM + 1;
  localparam int N_ST        = ST_SUM + 1;

  localparam logic [WORD_W-1:0] WORD_MARK = 32'h8000_0000;
  localparam logic [7:0]        ALPHA_MAX = 8'd255;

  typedef enum logic [2:0] {
    REG_POS_X, REG_POS_Y, REG_RECT_W, REG_RECT_H,
    REG_RADIUS, REG_SRC_COLS, REG_SRC_ROWS, REG_ALPHA
  } reg_idx_t;

  typedef enum logic {
    REQ_LOAD = 1'b0,
    REQ_DRAW = 1'b1
  } req_t;

  typedef struct packed {
    req_t              kind;
    logic              ok;
    logic [15:0]       idx;
    logic [RGB_W-1:0]  scol;
    logic [RGB_W-1:0]  dst;
    logic [FB_W-1:0]   addr;
  } meta_t;

  // x / 255 for x <= 255*255
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
    return t[15:8];
  endfunction

endpackage

[design/scaled_rounded_alpha_blit.sv]
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid / in_stall  | req_type, src_index, src_color, row, column, dst_color
// out     | output    | out_valid / out_stall| write_enable, fb_address, new_word
// cfg     | input     | cfg_we               | cfg_index, cfg_data
//
// One item per clock sustained while the output is not stalled.
// Most of the pipeline is the 9-step restoring divider (one quotient bit per stage)
// ahead of the single source store port.
// Loads travel the same pipeline and write the store at the stage where draws read,
// so item order holds with no forwarding. Load items produce no output transfer.
// Reset (synchronous, rst_n low) clears valid bits and config; the store is not cleared.
// A stalled output holding a valid item freezes the whole pipeline, and in_stall follows.
module scaled_rounded_alpha_blit
  import srab_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_req_type,
  input  logic [15:0]              in_src_index,
  input  logic [RGB_W-1:0]         in_src_color,
  input  logic [DIM_W-1:0]         in_row,
  input  logic [DIM_W-1:0]         in_column,
  input  logic [RGB_W-1:0]         in_dst_color,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     out_write_enable,
  output logic [FB_W-1:0]          out_fb_address,
  output logic [WORD_W-1:0]        out_new_word,
  input  logic                     cfg_we,
  input  logic [2:0]               cfg_index,
  input  logic [CFG_W-1:0]         cfg_data
);

  // configuration
  logic signed [12:0]    pos_x_r, pos_y_r;
  logic [DIM_W-1:0]      rect_w_r, rect_h_r;
  logic [10:0]           radius_r;
  logic [SRC_DIM_W-1:0]  src_cols_r, src_rows_r;
  logic [7:0]            alpha_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r    <= '0;
      pos_y_r    <= '0;
      rect_w_r   <= '0;
      rect_h_r   <= '0;
      radius_r   <= '0;
      src_cols_r <= '0;
      src_rows_r <= '0;
      alpha_r    <= ALPHA_MAX;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_POS_X:    pos_x_r    <= cfg_data;
        REG_POS_Y:    pos_y_r    <= cfg_data;
        REG_RECT_W:   rect_w_r   <= cfg_data[DIM_W-1:0];
        REG_RECT_H:   rect_h_r   <= cfg_data[DIM_W-1:0];
        REG_RADIUS:   radius_r   <= cfg_data[10:0];
        REG_SRC_COLS: src_cols_r <= cfg_data[SRC_DIM_W-1:0];
        REG_SRC_ROWS: src_rows_r <= cfg_data[SRC_DIM_W-1:0];
        REG_ALPHA:    alpha_r    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // whole pipeline moves together; the output register decouples the sink
  logic adv;
  logic out_valid_r;
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  logic              vld_r  [N_ST];
  meta_t             meta_r [N_ST];
  meta_t             meta_nxt [N_ST];

  // stage 0 front end: clip, screen position, corner offsets, dividends
  logic signed [13:0] sy_w, sx_w, cx_w, cy_w, wr_w, hr_w, dx_w, dy_w;
  logic signed [13:0] px_w, py_w, rad_w;
  logic               ok0_w;
  meta_t              meta0_w;

  always_comb begin
    px_w  = $signed({2'b00, in_column});
    py_w  = $signed({2'b00, in_row});
    rad_w = $signed({3'b000, radius_r});
    sy_w  = 14'(pos_y_r) + py_w;
    sx_w  = 14'(pos_x_r) + px_w;
    wr_w  = $signed({2'b00, rect_w_r}) - rad_w;
    hr_w  = $signed({2'b00, rect_h_r}) - rad_w;
    // asymmetric corner centres: radius low side, size-radius-1 high side
    cx_w  = (px_w < rad_w) ? rad_w : ((px_w >= wr_w) ? wr_w - 14'sd1 : px_w);
    cy_w  = (py_w < rad_w) ? rad_w : ((py_w >= hr_w) ? hr_w - 14'sd1 : py_w);
    dx_w  = px_w - cx_w;
    dy_w  = py_w - cy_w;
    ok0_w = (rect_w_r != '0) && (rect_h_r != '0) && (src_cols_r != '0)
            && (src_rows_r != '0) && (in_row < rect_h_r) && (in_column < rect_w_r)
            && (sy_w >= 14'sd0) && (sy_w < 14'(SCREEN_HEIGHT))
            && (sx_w >= 14'sd0) && (sx_w < 14'(SCREEN_WIDTH));
    meta0_w.kind = req_t'(in_req_type);
    meta0_w.ok   = ok0_w;
    meta0_w.idx  = in_src_index;
    meta0_w.scol = in_src_color;
    meta0_w.dst  = in_dst_color;
    meta0_w.addr = '0;
  end

  logic [DIM_W-1:0]        sy_r, sx_r;
  logic signed [11:0]      dx_r, dy_r;
  logic [21:0]             sqx_r, sqy_r, rr_r;
  logic [PROD_W-1:0]       rem_row_r [Q_W+1];
  logic [PROD_W-1:0]       rem_col_r [Q_W+1];
  logic [Q_W-1:0]          q_row_r   [Q_W+1];
  logic [Q_W-1:0]          q_col_r   [Q_W+1];
  logic [PROD_W-1:0]       rem_row_nxt [Q_W+1];
  logic [PROD_W-1:0]       rem_col_nxt [Q_W+1];
  logic [Q_W-1:0]          q_row_nxt   [Q_W+1];
  logic [Q_W-1:0]          q_col_nxt   [Q_W+1];

  // restoring divide, one quotient bit per stage, MSB first
  always_comb begin
    logic [PROD_W-1:0] dh, dw;
    rem_row_nxt[0] = PROD_W'(in_row) * PROD_W'(src_rows_r);
    rem_col_nxt[0] = PROD_W'(in_column) * PROD_W'(src_cols_r);
    q_row_nxt[0]   = '0;
    q_col_nxt[0]   = '0;
    for (int i = 1; i <= Q_W; i++) begin
      dh = PROD_W'(rect_h_r) << (Q_W - i);
      dw = PROD_W'(rect_w_r) << (Q_W - i);
      rem_row_nxt[i] = rem_row_r[i-1];
      rem_col_nxt[i] = rem_col_r[i-1];
      q_row_nxt[i]   = q_row_r[i-1];
      q_col_nxt[i]   = q_col_r[i-1];
      if (rem_row_r[i-1] >= dh) begin
        rem_row_nxt[i]         = rem_row_r[i-1] - dh;
        q_row_nxt[i][Q_W - i]  = 1'b1;
      end
      if (rem_col_r[i-1] >= dw) begin
        rem_col_nxt[i]         = rem_col_r[i-1] - dw;
        q_col_nxt[i][Q_W - i]  = 1'b1;
      end
    end
  end

  // meta moves down; address filled at stage 1, mask folded at stage 2
  logic [23:0] addr_w;
  logic        inside_w;
  always_comb begin
    addr_w   = 24'(sy_r) * 24'(SCREEN_WIDTH) + 24'(sx_r);
    inside_w = (radius_r == '0) || ((23'(sqx_r) + 23'(sqy_r)) <= 23'(rr_r));
    meta_nxt[0] = meta0_w;
    for (int i = 1; i < N_ST; i++) meta_nxt[i] = meta_r[i-1];
    meta_nxt[1].addr = addr_w[FB_W-1:0];
    meta_nxt[2].ok   = meta_r[1].ok && inside_w;
  end

  // source index and range check
  logic [SIDX_W-1:0]  sidx_w;
  logic [SRC_AW-1:0]  sidx_r;
  logic               sidx_ok_r;
  assign sidx_w = SIDX_W'(q_row_r[ST_DIV_LAST]) * SIDX_W'(src_cols_r)
                  + SIDX_W'(q_col_r[ST_DIV_LAST]);

  // source store, one port: loads write and draws read at the same stage
  logic [RGB_W-1:0] src_mem [SOURCE_DEPTH];
  logic [RGB_W-1:0] rd_r;
  logic             rd_ok_r;

  logic [15:0] sum_w [3];
  logic [15:0] sum_r [3];
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      sum_w[ch] = 16'(rd_ok_r ? rd_r[ch*8 +: 8] : 8'd0) * 16'(alpha_r)
                + 16'(meta_r[ST_MEM].dst[ch*8 +: 8]) * 16'(ALPHA_MAX - alpha_r);
    end
  end

  logic                out_we_r;
  logic [FB_W-1:0]     out_addr_r;
  logic [WORD_W-1:0]   out_word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < N_ST; i++) vld_r[i] <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_valid;
      for (int i = 1; i < N_ST; i++) vld_r[i] <= vld_r[i-1];
      out_valid_r <= vld_r[ST_SUM] && (meta_r[ST_SUM].kind == REQ_DRAW);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < N_ST; i++) meta_r[i] <= meta_nxt[i];
      for (int i = 0; i <= Q_W; i++) begin
        rem_row_r[i] <= rem_row_nxt[i];
        rem_col_r[i] <= rem_col_nxt[i];
        q_row_r[i]   <= q_row_nxt[i];
        q_col_r[i]   <= q_col_nxt[i];
      end
      sy_r  <= sy_w[DIM_W-1:0];
      sx_r  <= sx_w[DIM_W-1:0];
      dx_r  <= dx_w[11:0];
      dy_r  <= dy_w[11:0];
      sqx_r <= 22'(dx_r) * 22'(dx_r);
      sqy_r <= 22'(dy_r) * 22'(dy_r);
      rr_r  <= 22'(radius_r) * 22'(radius_r);
      sidx_r    <= sidx_w[SRC_AW-1:0];
      sidx_ok_r <= (sidx_w < SIDX_W'(SOURCE_DEPTH));
      rd_ok_r   <= sidx_ok_r;
      for (int ch = 0; ch < 3; ch++) sum_r[ch] <= sum_w[ch];
      out_we_r   <= meta_r[ST_SUM].ok;
      out_addr_r <= meta_r[ST_SUM].ok ? meta_r[ST_SUM].addr : '0;
      out_word_r <= meta_r[ST_SUM].ok
                    ? (WORD_MARK | {8'd0, div255(sum_r[2]), div255(sum_r[1]),
                                    div255(sum_r[0])})
                    : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (vld_r[ST_IDX] && (meta_r[ST_IDX].kind == REQ_LOAD)
          && (17'(meta_r[ST_IDX].idx) < 17'(SOURCE_DEPTH))) begin
        src_mem[meta_r[ST_IDX].idx[SRC_AW-1:0]] <= meta_r[ST_IDX].scol;
      end
      rd_r <= src_mem[sidx_r];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_write_enable = out_we_r;
  assign out_fb_address   = out_addr_r;
  assign out_new_word     = out_word_r;

  a_stall_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid_r && out_stall))
    else $error("input stall does not follow output backpressure");

  a_zero_when_clipped: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_write_enable) |-> (out_fb_address == '0 && out_new_word == '0))
    else $error("clipped pixel carries nonzero payload");

  a_mark_bit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_write_enable) |-> out_new_word[WORD_W-1])
    else $error("written word lacks marker bit");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule
